// File: rtl/core/trb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package trb_pkg;

    localparam int DEPTH     = 64;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int TIME_BITS = 48;
    localparam int PRICE_W   = 64;
    localparam int VOL_W     = 31;
    localparam int FIELD_W   = TIME_BITS + PRICE_W + VOL_W;
    localparam int DATA_W    = ((FIELD_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_EMIT
    } trb_state_t;

    typedef struct packed {
        logic capture;
        logic insert;
        logic emit;
    } trb_cmd_t;

    typedef struct packed {
        logic can_emit;
        logic emit_last;
        logic out_free;
    } trb_status_t;

endpackage

`default_nettype wire

// File: rtl/core/trb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module trb_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire trb_pkg::trb_status_t status,
    output trb_pkg::trb_cmd_t        cmd
);
    import trb_pkg::*;

    trb_state_t state_reg;
    trb_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!status.can_emit)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/trb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module trb_datapath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire trb_pkg::trb_cmd_t            cmd,
    output trb_pkg::trb_status_t              status,
    input  wire logic [trb_pkg::TIME_BITS-1:0] in_time,
    input  wire logic [trb_pkg::PRICE_W-1:0]   in_price,
    input  wire logic [trb_pkg::VOL_W-1:0]     in_volume,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [trb_pkg::TIME_BITS-1:0]     out_time,
    output logic [trb_pkg::PRICE_W-1:0]       out_price,
    output logic [trb_pkg::VOL_W-1:0]         out_volume,
    output logic                              out_last
);
    import trb_pkg::*;

    logic [TIME_BITS-1:0] time_reg  [DEPTH];
    logic [PRICE_W-1:0]   price_reg [DEPTH];
    logic [VOL_W-1:0]     vol_reg   [DEPTH];
    logic [TIME_BITS-1:0] time_next [DEPTH];
    logic [PRICE_W-1:0]   price_next[DEPTH];
    logic [VOL_W-1:0]     vol_next  [DEPTH];

    logic [TIME_BITS-1:0] hold_time_reg;
    logic [PRICE_W-1:0]   hold_price_reg;
    logic [VOL_W-1:0]     hold_vol_reg;

    logic [CNT_W-1:0]     fill_reg;
    logic [CNT_W-1:0]     fill_next;
    logic                 emitted_reg;
    logic [TIME_BITS-1:0] last_time_reg;

    logic                 out_valid_reg;
    logic                 out_last_reg;
    logic [TIME_BITS-1:0] out_time_reg;
    logic [PRICE_W-1:0]   out_price_reg;
    logic [VOL_W-1:0]     out_vol_reg;

    logic                 full;
    logic                 shift_down;
    logic                 store_we;
    logic [DEPTH-1:0]     gt;

    assign full       = (fill_reg == CNT_W'(DEPTH));
    assign shift_down = (cmd.capture && full) || cmd.emit;
    assign store_we   = shift_down || cmd.insert;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            gt[i] = (CNT_W'(i) < fill_reg) && (time_reg[i] > hold_time_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            time_next[i]  = time_reg[i];
            price_next[i] = price_reg[i];
            vol_next[i]   = vol_reg[i];
            if (shift_down)
            begin
                if (i < DEPTH - 1)
                begin
                    time_next[i]  = time_reg[i + 1];
                    price_next[i] = price_reg[i + 1];
                    vol_next[i]   = vol_reg[i + 1];
                end
            end
            else if ((i > 0) && gt[(i > 0) ? i - 1 : 0])
            begin
                time_next[i]  = time_reg[(i > 0) ? i - 1 : 0];
                price_next[i] = price_reg[(i > 0) ? i - 1 : 0];
                vol_next[i]   = vol_reg[(i > 0) ? i - 1 : 0];
            end
            else if (gt[i] || (CNT_W'(i) == fill_reg))
            begin
                time_next[i]  = hold_time_reg;
                price_next[i] = hold_price_reg;
                vol_next[i]   = hold_vol_reg;
            end
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (shift_down)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
        else if (cmd.insert)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                time_reg[i]  <= time_next[i];
                price_reg[i] <= price_next[i];
                vol_reg[i]   <= vol_next[i];
            end
        end
        if (cmd.capture)
        begin
            hold_time_reg  <= in_time;
            hold_price_reg <= in_price;
            hold_vol_reg   <= in_volume;
        end
        if (cmd.emit)
        begin
            out_time_reg  <= time_reg[0];
            out_price_reg <= price_reg[0];
            out_vol_reg   <= vol_reg[0];
            out_last_reg  <= status.emit_last;
            last_time_reg <= time_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            emitted_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (cmd.emit)
            begin
                emitted_reg   <= 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // An emitted item ends its run when the store empties or the next time equals it.
    assign status.can_emit  = (fill_reg != '0) &&
                              (!emitted_reg || (time_reg[0] > last_time_reg));
    assign status.emit_last = (fill_reg == CNT_W'(1)) || (time_reg[1] == time_reg[0]);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_time   = out_time_reg;
    assign out_price  = out_price_reg;
    assign out_volume = out_vol_reg;
    assign out_last   = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/core/timestamp_reorder_buffer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Signals                       Contents
// s_axis    in         s_tvalid s_tready s_tdata     one timestamped record
// m_axis    out        m_tvalid m_tready m_tdata     one released record, tlast ends the run
//
// An item is captured (dropping the front entry when the store is full), then placed by a
// sorted insert into the shift-register store, then released record by record while
// m_tready allows, or given a single check when nothing is released.
// Reset clears the fill count, the emitted flag and the output valid flag.
// A stalled m_tready holds the output register and pauses release; input waits meanwhile.

module timestamp_reorder_buffer_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // event_time [47:0], price_word [111:48], volume [142:112], zero [143]
    input  wire logic [trb_pkg::DATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // out_time [47:0], out_price_word [111:48], out_volume [142:112], zero [143]
    output logic [trb_pkg::DATA_W-1:0]       m_tdata,
    output logic                             m_tlast
);
    import trb_pkg::*;

    trb_cmd_t             cmd;
    trb_status_t          status;
    logic [TIME_BITS-1:0] out_time;
    logic [PRICE_W-1:0]   out_price;
    logic [VOL_W-1:0]     out_volume;

    trb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    trb_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_time    (s_tdata[TIME_BITS-1:0]),
        .in_price   (s_tdata[TIME_BITS+PRICE_W-1:TIME_BITS]),
        .in_volume  (s_tdata[FIELD_W-1:TIME_BITS+PRICE_W]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_time   (out_time),
        .out_price  (out_price),
        .out_volume (out_volume),
        .out_last   (m_tlast)
    );

    assign m_tdata = {(DATA_W - FIELD_W)'(0), out_volume, out_price, out_time};

endmodule

`default_nettype wire
